// ----- design/hsfc_pkg.sv -----
package hsfc_pkg;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_IDX_POLY = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_IDX_INIT = 2'd1;
  localparam logic [7:0] CRC_POLY_RESET = 8'h31;
  localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

  // Conversion constants: span and offset in hundredths.
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [14:0] HUM_SPAN    = 15'd12500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;

  // Position of a byte within the six-byte frame.
  typedef enum logic [2:0] {
    POS_TEMP_HI = 3'd0,
    POS_TEMP_LO = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI = 3'd3,
    POS_HUM_LO = 3'd4,
    POS_HUM_CRC = 3'd5
  } pos_e;

  // A finished frame handed from the frame tracker to the converter.
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_done_t;

  // One CRC-8 byte update, MSB first.
  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] data,
                                          logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // floor(raw * span / 65535) - offset, kept to 15 bits. The quotient by
  // 65535 is the high half of the product plus a one-step correction.
  function automatic logic [14:0] scale_offset(logic [15:0] raw, logic [14:0] span,
                                               logic [14:0] offset);
    logic [30:0] prod;
    logic [14:0] quot;
    logic [16:0] rem;
    logic [14:0] q;
    prod = 31'(raw) * 31'(span);
    quot = prod[30:16];
    rem  = 17'(prod[15:0]) + 17'(quot);
    q    = quot + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
    return q - offset;
  endfunction

endpackage

// ----- design/hsfc_frame_track.sv -----
module hsfc_frame_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  input  logic [7:0]           crc_poly_i,
  input  logic [7:0]           crc_init_i,
  input  logic                 out_free_i,
  output hsfc_pkg::frame_done_t done_o,
  output hsfc_pkg::pos_e       pos_o
);
  import hsfc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  rx_q;
  logic        start_q;
  pos_e        pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_next;
  logic [15:0] temp_word_q, temp_word_d;
  logic [7:0]  hum_hi_q, hum_hi_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic        first_good_q, first_good_d;
  logic        fire;

  // Input register byte is handled; the last byte waits for result room.
  assign pos_eff    = start_q ? POS_TEMP_HI : pos_q;
  assign fire       = in_valid_q && ((pos_eff != POS_HUM_CRC) || out_free_i);
  assign in_ready_o = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q    <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  // Frame state update for the byte being handled.
  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    temp_word_d  = temp_word_q;
    hum_hi_d     = hum_hi_q;
    hum_word_d   = hum_word_q;
    first_good_d = first_good_q;
    crc_next     = crc_feed((pos_eff == POS_TEMP_HI || pos_eff == POS_HUM_HI) ?
                            crc_init_i : crc_q, rx_q, crc_poly_i);
    if (fire) begin
      unique case (pos_eff)
        POS_TEMP_HI: begin
          crc_d       = crc_next;
          temp_word_d = {rx_q, 8'h00};
          pos_d       = POS_TEMP_LO;
        end
        POS_TEMP_LO: begin
          crc_d       = crc_next;
          temp_word_d = {temp_word_q[15:8], rx_q};
          pos_d       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          first_good_d = (crc_q == rx_q);
          pos_d        = POS_HUM_HI;
        end
        POS_HUM_HI: begin
          crc_d    = crc_next;
          hum_hi_d = rx_q;
          pos_d    = POS_HUM_LO;
        end
        POS_HUM_LO: begin
          crc_d      = crc_next;
          hum_word_d = {hum_hi_q, rx_q};
          pos_d      = POS_HUM_CRC;
        end
        POS_HUM_CRC: begin
          pos_d = POS_TEMP_HI;
        end
        default: begin
          pos_d = POS_TEMP_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_TEMP_HI;
      crc_q        <= CRC_INIT_RESET;
      temp_word_q  <= '0;
      hum_hi_q     <= '0;
      hum_word_q   <= '0;
      first_good_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      temp_word_q  <= temp_word_d;
      hum_hi_q     <= hum_hi_d;
      hum_word_q   <= hum_word_d;
      first_good_q <= first_good_d;
    end
  end

  // The last byte closes the frame and checks the second CRC.
  assign done_o.valid    = fire && (pos_eff == POS_HUM_CRC);
  assign done_o.ok       = first_good_q && (crc_q == rx_q);
  assign done_o.temp_raw = temp_word_q;
  assign done_o.hum_raw  = hum_word_q;
  assign pos_o           = pos_q;

endmodule

// ----- design/hsfc_convert.sv -----
module hsfc_convert (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsfc_pkg::frame_done_t done_i,
  output logic                  out_free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [14:0]    temperature_centi_o,
  output logic signed [14:0]    humidity_centi_o,
  output logic [15:0]           temperature_raw_o,
  output logic [15:0]           humidity_raw_o,
  output logic                  crc_ok_o
);
  import hsfc_pkg::*;

  logic        out_valid_q;
  logic [14:0] temp_centi_q, hum_centi_q;
  logic [15:0] temp_raw_q, hum_raw_q;
  logic        ok_q;

  assign out_free_o = !out_valid_q || out_ready_i;

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Scale both words; a failed check zeroes the converted values.
  always_ff @(posedge clk_i) begin
    if (done_i.valid) begin
      temp_centi_q <= done_i.ok ? scale_offset(done_i.temp_raw, TEMP_SPAN, TEMP_OFFSET)
                                : '0;
      hum_centi_q  <= done_i.ok ? scale_offset(done_i.hum_raw, HUM_SPAN, HUM_OFFSET)
                                : '0;
      temp_raw_q   <= done_i.temp_raw;
      hum_raw_q    <= done_i.hum_raw;
      ok_q         <= done_i.ok;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = $signed(temp_centi_q);
  assign humidity_centi_o    = $signed(hum_centi_q);
  assign temperature_raw_o   = temp_raw_q;
  assign humidity_raw_o      = hum_raw_q;
  assign crc_ok_o            = ok_q;

endmodule

// ----- design/humidity_sensor_frame_check.sv -----
// Checks and converts a six-byte temperature/humidity sensor frame, one byte
// per item, and gives one result after the sixth byte. A byte is taken every
// clock cycle while input is not held back: it lands in an input register,
// and from there its CRC step and, for the last byte, the scaling run in one
// pass into the result register. Input is held back only while a finished
// result waits in the result register and the byte in hand would close the
// next frame. Register 0 sets the CRC polynomial and register 1 the initial
// value; writes are taken every cycle and other indexes are ignored.
module humidity_sensor_frame_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hsfc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [14:0]            temperature_centi_o,
  output logic signed [14:0]            humidity_centi_o,
  output logic [15:0]                   temperature_raw_o,
  output logic [15:0]                   humidity_raw_o,
  output logic                          crc_ok_o
);
  import hsfc_pkg::*;

  logic [7:0]  crc_poly_q, crc_init_q;
  frame_done_t done;
  pos_e        pos;
  logic        out_free;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= CRC_POLY_RESET;
      crc_init_q <= CRC_INIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_POLY: crc_poly_q <= cfg_data_i;
        CFG_IDX_INIT: crc_init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hsfc_frame_track u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .crc_poly_i    (crc_poly_q),
    .crc_init_i    (crc_init_q),
    .out_free_i    (out_free),
    .done_o        (done),
    .pos_o         (pos)
  );

  hsfc_convert u_convert (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .done_i              (done),
    .out_free_o          (out_free),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_raw_o   (temperature_raw_o),
    .humidity_raw_o      (humidity_raw_o),
    .crc_ok_o            (crc_ok_o)
  );

  // A finished frame never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> (!out_valid_o || out_ready_i))
    else $error("frame result overwrote a pending result");

  // A taken result with no new frame behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !done.valid) |=> !out_valid_o)
    else $error("result delivered twice");

  // A failed check reports zero converted values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !crc_ok_o) |-> (temperature_centi_o == 15'sd0 &&
                                    humidity_centi_o == 15'sd0))
    else $error("converted values nonzero on CRC failure");

  // Closing a frame always returns the byte count to the first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |=> (pos == POS_TEMP_HI))
    else $error("byte count not restarted after frame end");

endmodule
